// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_DISPLAY    = 3'd4;

	localparam int VALUE_W = 32;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_DISPLAY
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_OVERFLOW  = 2'd1,
		STAT_UNDERFLOW = 2'd2,
		STAT_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DISP
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
	} deq_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/deq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/deq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_front
	import deq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [2:0]         cmd,
	input  wire logic [VALUE_W-1:0] push_value,
	output      logic               cq_valid,
	input  wire logic               cq_ready,
	output      deq_cmd_t           cq_data
);

	deq_cmd_t   slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       cmd_ok;
	op_t        cmd_op;
	logic       push;
	logic       pop;

	// Unused command codes are accepted and dropped here.
	always_comb begin
		cmd_ok = 1'b1;
		cmd_op = OP_DISPLAY;
		unique case (cmd)
			CMD_PUSH_FRONT: cmd_op = OP_PUSH_FRONT;
			CMD_PUSH_BACK:  cmd_op = OP_PUSH_BACK;
			CMD_POP_FRONT:  cmd_op = OP_POP_FRONT;
			CMD_POP_BACK:   cmd_op = OP_POP_BACK;
			CMD_DISPLAY:    cmd_op = OP_DISPLAY;
			default:        cmd_ok = 1'b0;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign cq_valid = (fill_q != 2'd0);
	assign cq_data  = slot_q[rd_ptr_q];
	assign push     = in_valid && in_ready && cmd_ok;
	assign pop      = cq_valid && cq_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{op: cmd_op, value: push_value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/deq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module deq_back
	import deq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cq_valid,
	output      logic               cq_ready,
	input  wire deq_cmd_t           cq_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [VALUE_W-1:0] out_value,
	output      logic [1:0]         status,
	output      logic               last
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);
	localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);
	localparam logic [IW:0]   SPAN_C  = (IW + 1)'(DEPTH);

	state_t             state_q;
	state_t             state_d;
	logic [IW-1:0]      front_q;
	logic [IW-1:0]      front_d;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      pos_d;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      idx_d;
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	status_t            status_q;
	logic               last_q;

	logic               slot_free;
	logic               take;
	logic               full;
	logic               empty;
	logic               load;
	logic [VALUE_W-1:0] res_value;
	status_t            res_status;
	logic               res_last;
	logic               we;
	logic               re;
	logic [IW-1:0]      waddr;
	logic [IW-1:0]      raddr;
	logic [VALUE_W-1:0] rdata;
	logic [IW:0]        tail_sum;
	logic [IW:0]        back_sum;
	logic [IW-1:0]      tail_pos;
	logic [IW-1:0]      back_pos;
	logic [IW-1:0]      pos_next;
	logic               disp_end;

	function automatic logic [IW-1:0] wrap_sum(input logic [IW:0] s);
		logic [IW:0] r;
		r = (s >= SPAN_C) ? (s - SPAN_C) : s;
		return r[IW-1:0];
	endfunction

	deq_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cq_data.value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign take      = (state_q == S_IDLE) && cq_valid && slot_free;
	assign full      = (count_q == FULL_C);
	assign empty     = (count_q == '0);
	assign tail_sum  = {1'b0, front_q} + (IW + 1)'(count_q);
	assign back_sum  = {1'b0, front_q} + (IW + 1)'(count_q - 1'b1);
	assign tail_pos  = wrap_sum(tail_sum);
	assign back_pos  = wrap_sum(back_sum);
	assign pos_next  = (pos_q == LAST_IX) ? '0 : pos_q + 1'b1;
	assign disp_end  = ((idx_q + 1'b1) == count_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take && !empty) begin
					if (cq_data.op == OP_POP_FRONT || cq_data.op == OP_POP_BACK) begin
						state_d = S_POP;
					end else if (cq_data.op == OP_DISPLAY) begin
						state_d = S_DISP;
					end
				end
			end
			S_POP: state_d = S_IDLE;
			S_DISP: begin
				if (slot_free && disp_end) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cq_ready   = 1'b0;
		load       = 1'b0;
		res_value  = '0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		we         = 1'b0;
		waddr      = front_q;
		re         = 1'b0;
		raddr      = front_q;
		front_d    = front_q;
		count_d    = count_q;
		pos_d      = pos_q;
		idx_d      = idx_q;
		unique case (state_q)
			S_IDLE: begin
				cq_ready = slot_free;
				if (take) begin
					unique case (cq_data.op)
						OP_PUSH_FRONT: begin
							load = 1'b1;
							if (full) begin
								res_status = STAT_OVERFLOW;
							end else begin
								front_d = (front_q == '0) ? LAST_IX : front_q - 1'b1;
								we      = 1'b1;
								waddr   = front_d;
								count_d = count_q + 1'b1;
							end
						end
						OP_PUSH_BACK: begin
							load = 1'b1;
							if (full) begin
								res_status = STAT_OVERFLOW;
							end else begin
								we      = 1'b1;
								waddr   = tail_pos;
								count_d = count_q + 1'b1;
							end
						end
						OP_POP_FRONT: begin
							if (empty) begin
								load       = 1'b1;
								res_status = STAT_UNDERFLOW;
							end else begin
								re      = 1'b1;
								raddr   = front_q;
								front_d = (front_q == LAST_IX) ? '0 : front_q + 1'b1;
								count_d = count_q - 1'b1;
							end
						end
						OP_POP_BACK: begin
							if (empty) begin
								load       = 1'b1;
								res_status = STAT_UNDERFLOW;
							end else begin
								re      = 1'b1;
								raddr   = back_pos;
								count_d = count_q - 1'b1;
							end
						end
						OP_DISPLAY: begin
							if (empty) begin
								load       = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								re    = 1'b1;
								raddr = front_q;
								pos_d = front_q;
								idx_d = '0;
							end
						end
						default: ;
					endcase
				end
			end
			S_POP: begin
				load      = 1'b1;
				res_value = rdata;
			end
			S_DISP: begin
				if (slot_free) begin
					load      = 1'b1;
					res_value = rdata;
					res_last  = disp_end;
					if (!disp_end) begin
						re    = 1'b1;
						raddr = pos_next;
						pos_d = pos_next;
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			pos_q   <= pos_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_value_q <= res_value;
			status_q    <= res_status;
			last_q      <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("Entry count exceeds the store depth.");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= LAST_IX)
		else $error("Front index is outside the store.");

	a_pop_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> !out_valid_q)
		else $error("Pop read data arrived while the result register was occupied.");

	a_disp_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISP |-> count_q != '0 && idx_q < count_q)
		else $error("Display walk is outside the stored entries.");
`endif

endmodule

`default_nettype wire

// ===== rtl/double_ended_queue_unit.sv =====
// Bounded deque of signed 32-bit values kept in a ring buffer of DEPTH entries. Each
// transaction carries a command (push front, push back, pop front, pop back, display)
// and a value, and yields one result per command, except display, which yields one
// result per stored entry from front to back with last set on the final one, or one
// empty-status result when nothing is stored. Unused command codes are dropped with
// no result. A two-entry command queue separates the input from the execution engine.
// Pushes and failed operations finish in the idle state that takes them; successful
// pops go on to the pop state, and a display walks the entries in the display state
// while the output register is free, as the entry RAM has a single registered read port;
// results wait in an output register while new commands are still taken into the queue.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue_unit
	import deq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [2:0]         cmd,
	input  wire logic [VALUE_W-1:0] push_value,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic [VALUE_W-1:0] out_value,
	output      logic [1:0]         status,
	output      logic               last
);

	logic     cq_valid;
	logic     cq_ready;
	deq_cmd_t cq_data;

	deq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.push_value (push_value),
		.cq_valid   (cq_valid),
		.cq_ready   (cq_ready),
		.cq_data    (cq_data)
	);

	deq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq_valid  (cq_valid),
		.cq_ready  (cq_ready),
		.cq_data   (cq_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_value (out_value),
		.status    (status),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import deq_pkg::*;

	localparam int SLOTS = 16;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int HOLD_CYCLES = 80;
	localparam int RANDOM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 40;
	localparam int REPORT_LIMIT = 10;
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         st;
		logic               last;
	} deq_result_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [VALUE_W-1:0] value;
		logic [4:0]         reps;
		logic               typed;
		logic [1:0]         st;
		logic [VALUE_W-1:0] result_value;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [2:0]         cmd = CMD_PUSH_FRONT;
	logic [VALUE_W-1:0] push_value = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [VALUE_W-1:0] out_value;
	logic [1:0]         status;
	logic               last;

	logic [VALUE_W-1:0] ring [SLOTS];
	logic [SLOT_W-1:0]  head = '0;
	int                 fill = 0;
	deq_result_t        want_q [$];
	stim_row_t          plan [$];
	int                 bad_count = 0;
	int                 snd_calm = 0;
	int                 rcv_calm = 0;
	bit                 hold_req = 1'b0;

	double_ended_queue_unit #(
		.DEPTH(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.push_value(push_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_value(out_value),
		.status(status),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic expect_result(input logic [VALUE_W-1:0] v, input logic [1:0] st,
			input logic lst);
		want_q.push_back({v, st, lst});
	endtask

	task automatic predict_item(input logic [2:0] op, input logic [VALUE_W-1:0] v);
		logic [SLOT_W-1:0] slot;
		int k;
		case (op)
		CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
			if (fill == SLOTS) begin
				expect_result('0, STAT_OVERFLOW, 1'b1);
			end else begin
				if (op == CMD_PUSH_FRONT) begin
					head = head - 1'b1;
					slot = head;
				end else begin
					slot = SLOT_W'(head + fill);
				end
				ring[slot] = v;
				fill++;
				expect_result('0, STAT_OK, 1'b1);
			end
		end
		CMD_POP_FRONT: begin
			if (fill == 0) begin
				expect_result('0, STAT_UNDERFLOW, 1'b1);
			end else begin
				expect_result(ring[head], STAT_OK, 1'b1);
				head = head + 1'b1;
				fill--;
			end
		end
		CMD_POP_BACK: begin
			if (fill == 0) begin
				expect_result('0, STAT_UNDERFLOW, 1'b1);
			end else begin
				slot = SLOT_W'(head + fill - 1);
				expect_result(ring[slot], STAT_OK, 1'b1);
				fill--;
			end
		end
		CMD_DISPLAY: begin
			if (fill == 0) begin
				expect_result('0, STAT_EMPTY, 1'b1);
			end else begin
				for (k = 0; k < fill; k++) begin
					slot = SLOT_W'(head + k);
					expect_result(ring[slot], STAT_OK, k == fill - 1);
				end
			end
		end
		default: begin
		end
		endcase
	endtask

	function automatic int draw_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 11) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	task automatic note_bad(input string field, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		bad_count++;
		if (bad_count <= REPORT_LIMIT)
			$display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
	endtask

	task automatic offer(input logic [2:0] op, input logic [VALUE_W-1:0] v,
			input logic typed, input logic [1:0] st, input logic [VALUE_W-1:0] rv);
		int gap;
		gap = draw_gap(snd_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		push_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_item(op, v);
		if (typed) begin
			void'(want_q.pop_back());
			want_q.push_back({rv, st, 1'b1});
		end
		@(negedge clk);
	endtask

	function automatic void add_row(input logic [2:0] op, input logic [VALUE_W-1:0] v,
			input logic [4:0] reps, input logic typed, input logic [1:0] st,
			input logic [VALUE_W-1:0] rv);
		plan.push_back({op, v, reps, typed, st, rv});
	endfunction

	always @(posedge clk) begin : result_check
		deq_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (want_q.size() == 0) begin
				note_bad("unexpected transaction", '0, out_value);
			end else begin
				want = want_q.pop_front();
				if (out_value !== want.value) note_bad("out_value", want.value, out_value);
				if (status !== want.st) note_bad("status", want.st, status);
				if (last !== want.last) note_bad("last", want.last, last);
			end
		end
	end

	initial begin : result_sink
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				gap = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				gap = draw_gap(rcv_calm);
			end
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int r;
		int k;
		int sent;
		int lean_left;
		int push_share;
		logic [2:0] op;
		logic [VALUE_W-1:0] v;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		add_row(CMD_POP_FRONT, '0, 1, 1'b1, STAT_UNDERFLOW, '0);
		add_row(CMD_POP_BACK, 32'h1234_5678, 1, 1'b1, STAT_UNDERFLOW, '0);
		add_row(CMD_DISPLAY, '0, 1, 1'b1, STAT_EMPTY, '0);
		add_row(CMD_SPARE_FIRST, '1, 1, 1'b0, STAT_OK, '0);
		add_row(CMD_SPARE_LAST, '1, 1, 1'b0, STAT_OK, '0);
		add_row(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1, STAT_OK, '0);
		add_row(CMD_PUSH_BACK, 32'h8000_0000, 1, 1'b1, STAT_OK, '0);
		add_row(CMD_DISPLAY, '0, 1, 1'b0, STAT_OK, '0);
		add_row(CMD_PUSH_FRONT, '0, 7, 1'b0, STAT_OK, '0);
		add_row(CMD_PUSH_BACK, 32'hFFFF_FFF0, 7, 1'b0, STAT_OK, '0);
		add_row(CMD_PUSH_FRONT, '0, 1, 1'b1, STAT_OVERFLOW, '0);
		add_row(CMD_PUSH_BACK, '1, 1, 1'b1, STAT_OVERFLOW, '0);
		add_row(CMD_DISPLAY, '0, 1, 1'b0, STAT_OK, '0);
		add_row(CMD_POP_BACK, '0, 1, 1'b1, STAT_OK, 32'hFFFF_FFF6);
		add_row(CMD_POP_FRONT, '0, 1, 1'b1, STAT_OK, 32'h0000_0006);

		for (r = 0; r < plan.size(); r++)
			for (k = 0; k < plan[r].reps; k++)
				offer(plan[r].op, plan[r].value + k, plan[r].typed, plan[r].st,
					plan[r].result_value);

		sent = 0;
		lean_left = 0;
		push_share = 50;
		while (sent < RANDOM_ITEMS) begin
			if (lean_left == 0) begin
				case ($urandom_range(0, 2))
				0: push_share = 80;
				1: push_share = 20;
				default: push_share = 50;
				endcase
				lean_left = $urandom_range(10, 30);
			end
			lean_left--;
			k = $urandom_range(0, 99);
			if (k < 4)
				op = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
			else if (k < 14)
				op = CMD_DISPLAY;
			else if ($urandom_range(0, 99) < push_share)
				op = $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
			case ($urandom_range(0, 7))
			0: v = 32'h7FFF_FFFF;
			1: v = 32'h8000_0000;
			2: v = '0;
			3: v = '1;
			default: v = $urandom;
			endcase
			if (sent == 60) begin
				hold_req = 1'b1;
				snd_calm = 20;
			end
			if (sent == 120) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (want_q.size() != 0);
			end
			offer(op, v, 1'b0, STAT_OK, '0);
			if (op <= CMD_DISPLAY) sent++;
		end

		in_valid <= 1'b0;
		while (want_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bad_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== double_ended_queue_unit.f =====
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue_unit.sv
sim/tb_top.sv
